// ===== hdl/dmth_pkg.sv =====
`default_nettype none
package dmth_pkg;

    localparam logic [31:0] DELTA     = 32'h9E37_79B9;
    localparam logic [31:0] SEED_LOW  = 32'h9464_a485;
    localparam logic [31:0] SEED_HIGH = 32'h542e_1a94;

    // index of the last round (rounds minus one)
    localparam logic [3:0] BLOCK_LAST_RND = 4'd5;
    localparam logic [3:0] FINAL_LAST_RND = 4'd9;

    typedef struct packed {
        logic wr_byte;   // store data byte, advance count
        logic ld_blk;    // snapshot full block, load a/b from chain
        logic ld_fin;    // snapshot padded final block, load a/b
        logic step_a;    // first half of a round
        logic step_b;    // second half of a round
        logic commit;    // feed-forward into the chain
        logic ld_out;    // capture h0 ^ h1
        logic clr;       // back to seeds, count to zero
    } t_cmd;

    typedef struct packed {
        logic pos_last;  // next byte completes a block
    } t_sts;

endpackage
`default_nettype wire

// ===== hdl/dmth_dp.sv =====
`default_nettype none
module dmth_dp (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire dmth_pkg::t_cmd i_cmd,
    input  wire logic [7:0]    i_data_byte,
    output dmth_pkg::t_sts     o_sts,
    output logic [31:0]        o_hash_value
);
    import dmth_pkg::*;

    logic [7:0]  r_buf [16];
    logic [31:0] r_cnt;
    logic [31:0] r_cl, r_ch;
    logic [31:0] r_a, r_b, r_acc;
    logic [31:0] r_w [4];
    logic [31:0] r_hash;

    logic [31:0] blk_w [4];
    logic [31:0] fin_w [4];
    logic [31:0] pad, pad_half;
    logic [1:0]  nw, tl;
    logic [31:0] acc_n, mix_a, mix_b;

    always_comb begin
        for (int j = 0; j < 4; j++) begin
            blk_w[j] = {r_buf[4*j+3], r_buf[4*j+2], r_buf[4*j+1], r_buf[4*j]};
        end
    end

    // final block: whole words, then partial word seeded with the pad, then pad
    always_comb begin
        logic [31:0] part;
        logic [7:0]  tb;
        pad_half = r_cnt | (r_cnt << 8);
        pad      = pad_half | (pad_half << 16);
        nw       = r_cnt[3:2];
        tl       = r_cnt[1:0];
        part     = pad;
        for (int k = 0; k < 3; k++) begin
            tb = r_buf[{nw, 2'(k)}];
            if (2'(k) < tl) begin
                part = (part << 8) | {{24{tb[7]}}, tb};
            end
        end
        for (int j = 0; j < 4; j++) begin
            if (2'(j) < nw) begin
                fin_w[j] = blk_w[j];
            end else if (2'(j) == nw) begin
                fin_w[j] = part;
            end else begin
                fin_w[j] = pad;
            end
        end
    end

    assign acc_n = r_acc + DELTA;
    assign mix_a = ((r_b << 4) + r_w[0]) ^ (r_b + acc_n) ^ ((r_b >> 5) + r_w[1]);
    assign mix_b = ((r_a << 4) + r_w[2]) ^ (r_a + r_acc) ^ ((r_a >> 5) + r_w[3]);

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_byte) begin
            r_buf[r_cnt[3:0]] <= i_data_byte;
        end
        if (i_cmd.ld_blk || i_cmd.ld_fin) begin
            for (int j = 0; j < 4; j++) begin
                r_w[j] <= i_cmd.ld_fin ? fin_w[j] : blk_w[j];
            end
            r_a   <= r_cl;
            r_b   <= r_ch;
            r_acc <= '0;
        end
        if (i_cmd.step_a) begin
            r_acc <= acc_n;
            r_a   <= r_a + mix_a;
        end
        if (i_cmd.step_b) begin
            r_b <= r_b + mix_b;
        end
        if (i_cmd.ld_out) begin
            r_hash <= r_cl ^ r_ch;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
            r_cl  <= SEED_LOW;
            r_ch  <= SEED_HIGH;
        end else begin
            if (i_cmd.clr) begin
                r_cnt <= '0;
                r_cl  <= SEED_LOW;
                r_ch  <= SEED_HIGH;
            end else begin
                if (i_cmd.wr_byte) begin
                    r_cnt <= r_cnt + 32'd1;
                end
                if (i_cmd.commit) begin
                    r_cl <= r_cl + r_a;
                    r_ch <= r_ch + r_b;
                end
            end
        end
    end

    assign o_sts.pos_last = (r_cnt[3:0] == 4'hF);
    assign o_hash_value   = r_hash;

endmodule
`default_nettype wire

// ===== hdl/dmth_ctrl.sv =====
`default_nettype none
module dmth_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    input  wire logic          i_byte_valid,
    input  wire logic          i_last,
    output logic               o_stall,
    output logic               o_valid,
    input  wire logic          i_stall,
    input  wire dmth_pkg::t_sts i_sts,
    output dmth_pkg::t_cmd     o_cmd
);
    import dmth_pkg::*;

    localparam logic [1:0] S_RUN  = 2'd0;
    localparam logic [1:0] S_FWAIT = 2'd1;
    localparam logic [1:0] S_FMIX = 2'd2;
    localparam logic [1:0] S_OUT  = 2'd3;

    localparam logic [1:0] M_IDLE = 2'd0;
    localparam logic [1:0] M_A    = 2'd1;
    localparam logic [1:0] M_B    = 2'd2;
    localparam logic [1:0] M_SUM  = 2'd3;

    logic [1:0] r_st, n_st;
    logic [1:0] r_mst, n_mst;
    logic [3:0] r_rnd, n_rnd;
    logic [3:0] r_rlim, n_rlim;
    logic       r_go, n_go;
    logic       r_ovalid, n_ovalid;
    logic       busy, in_acc, out_free;

    assign busy     = (r_mst != M_IDLE) || r_go;
    assign o_stall  = (r_st != S_RUN)
                    || (busy && (i_last || (i_byte_valid && i_sts.pos_last)));
    assign in_acc   = i_valid && !o_stall;
    assign out_free = !r_ovalid || !i_stall;

    always_comb begin
        o_cmd    = '0;
        n_st     = r_st;
        n_mst    = r_mst;
        n_rnd    = r_rnd;
        n_rlim   = r_rlim;
        n_go     = r_go;
        n_ovalid = r_ovalid && i_stall;

        unique case (r_st)
            S_RUN: begin
                if (in_acc) begin
                    o_cmd.wr_byte = i_byte_valid;
                    if (i_byte_valid && i_sts.pos_last) begin
                        n_go = 1'b1;
                    end
                    if (i_last) begin
                        n_st = S_FWAIT;
                    end
                end
            end
            S_FWAIT: begin
                if (!busy) begin
                    o_cmd.ld_fin = 1'b1;
                    n_mst  = M_A;
                    n_rnd  = '0;
                    n_rlim = FINAL_LAST_RND;
                    n_st   = S_FMIX;
                end
            end
            S_FMIX: begin
                if (!busy) begin
                    n_st = S_OUT;
                end
            end
            S_OUT: begin
                if (out_free) begin
                    o_cmd.ld_out = 1'b1;
                    o_cmd.clr    = 1'b1;
                    n_ovalid     = 1'b1;
                    n_st         = S_RUN;
                end
            end
            default: n_st = S_RUN;
        endcase

        unique case (r_mst)
            M_IDLE: begin
                if (r_go) begin
                    o_cmd.ld_blk = 1'b1;
                    n_go   = 1'b0;
                    n_mst  = M_A;
                    n_rnd  = '0;
                    n_rlim = BLOCK_LAST_RND;
                end
            end
            M_A: begin
                o_cmd.step_a = 1'b1;
                n_mst = M_B;
            end
            M_B: begin
                o_cmd.step_b = 1'b1;
                if (r_rnd == r_rlim) begin
                    n_mst = M_SUM;
                end else begin
                    n_rnd = r_rnd + 4'd1;
                    n_mst = M_A;
                end
            end
            M_SUM: begin
                o_cmd.commit = 1'b1;
                n_mst = M_IDLE;
            end
            default: n_mst = M_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st     <= S_RUN;
            r_mst    <= M_IDLE;
            r_rnd    <= '0;
            r_rlim   <= '0;
            r_go     <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_st     <= n_st;
            r_mst    <= n_mst;
            r_rnd    <= n_rnd;
            r_rlim   <= n_rlim;
            r_go     <= n_go;
            r_ovalid <= n_ovalid;
        end
    end

    assign o_valid = r_ovalid;

    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && i_byte_valid && i_sts.pos_last |-> !busy)
        else $error("block completed while mixer busy");

    a_go_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_go && r_mst == M_IDLE |=> r_mst == M_A && !r_go)
        else $error("pending block did not start");

    a_final_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_st == S_FWAIT && !busy |=> r_st == S_FMIX && r_mst == M_A
                                     && r_rlim == FINAL_LAST_RND)
        else $error("final block did not start");

    a_out_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_st == S_OUT |-> r_mst == M_IDLE && !r_go)
        else $error("result taken while mixer active");

endmodule
`default_nettype wire

// ===== hdl/davies_meyer_tea_string_hash.sv =====
// Byte words are taken one per cycle while o_stall is low; a full 16-byte block
// is mixed (one half-round per cycle in the round unit) while the next block
// streams in. A word with last is followed by the final 10-round block, mixed
// after the full block that the same word closes, if it closes one.
// Input stalls from the last word until the result enters the output register.
// Synchronous active-low reset: chain to seeds, byte count to zero, no result.
`default_nettype none
module davies_meyer_tea_string_hash (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // input channel: one message byte per word
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [7:0]  i_data_byte,
    input  wire logic        i_byte_valid,
    input  wire logic        i_last,
    // result channel
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic [31:0]      o_hash_value
);
    import dmth_pkg::*;

    t_cmd cmd;
    t_sts sts;

    // Controller: input acceptance, pending-block start, round sequencing
    // and the output register handshake.
    dmth_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .i_byte_valid (i_byte_valid),
        .i_last       (i_last),
        .o_stall      (o_stall),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .i_sts        (sts),
        .o_cmd        (cmd)
    );

    // Datapath: byte buffer, length counter, word snapshot (so the buffer can
    // refill during mixing), shared half-round unit and chain registers.
    dmth_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .i_data_byte  (i_data_byte),
        .o_sts        (sts),
        .o_hash_value (o_hash_value)
    );

endmodule
`default_nettype wire

// ===== tb/sv/davies_meyer_tea_string_hash_tb.sv =====
`default_nettype none

// Scoreboard with its own copy of the hash: chain pair, byte buffer and length.
// Each accepted input word updates that copy. A word with last queues the
// hash that the block should return.
class hash_scoreboard;

    localparam int BLOCK_ROUNDS = 6;
    localparam int FINAL_ROUNDS = 10;

    logic [31:0] chain_lo;
    logic [31:0] chain_hi;
    logic [31:0] n_bytes;
    logic [7:0]  blk [16];
    logic [31:0] hash_q [$];

    int unsigned errors;
    int unsigned hashes_checked;
    int unsigned bytes_noted;
    int unsigned messages_noted;

    function new();
        errors         = 0;
        hashes_checked = 0;
        bytes_noted    = 0;
        messages_noted = 0;
        restart();
    endfunction

    function void restart();
        chain_lo = dmth_pkg::SEED_LOW;
        chain_hi = dmth_pkg::SEED_HIGH;
        n_bytes  = '0;
        foreach (blk[i]) blk[i] = '0;
    endfunction

    // little-endian word from the buffer, starting at byte p
    function logic [31:0] le_word(int unsigned p);
        return {blk[(p + 3) % 16], blk[(p + 2) % 16], blk[(p + 1) % 16], blk[p % 16]};
    endfunction

    // TEA-style rounds on a copy of the chain, then the Davies-Meyer feed-forward
    function void mix(int rounds, logic [3:0][31:0] w);
        logic [31:0] acc;
        logic [31:0] a;
        logic [31:0] b;
        acc = '0;
        a   = chain_lo;
        b   = chain_hi;
        for (int r = 0; r < rounds; r++) begin
            acc = acc + dmth_pkg::DELTA;
            a = a + (((b << 4) + w[0]) ^ (b + acc) ^ ((b >> 5) + w[1]));
            b = b + (((a << 4) + w[2]) ^ (a + acc) ^ ((a >> 5) + w[3]));
        end
        chain_lo = chain_lo + a;
        chain_hi = chain_hi + b;
    endfunction

    function void note_word(logic [7:0] d, logic bv, logic lst);
        logic [3:0][31:0] w;
        logic [31:0]      pad;
        int unsigned      pos;
        int unsigned      rem;
        int unsigned      nw;
        int unsigned      tail;
        if (bv) begin
            pos      = n_bytes[3:0];
            blk[pos] = d;
            n_bytes  = n_bytes + 1;
            bytes_noted++;
            if (pos == 15) begin
                for (int j = 0; j < 4; j++) w[j] = le_word(j * 4);
                mix(BLOCK_ROUNDS, w);
            end
        end
        if (!lst) return;

        // final block: whole tail words, then the partial word on top of the
        // length pad, then pad words
        pad  = n_bytes | (n_bytes << 8);
        pad  = pad | (pad << 16);
        rem  = n_bytes[3:0];
        nw   = rem >> 2;
        tail = rem & 3;
        for (int j = 0; j < 4; j++) begin
            if (j < nw) begin
                w[j] = le_word(j * 4);
            end else begin
                w[j] = pad;
                if (j == nw) begin
                    for (int k = 0; k < tail; k++)
                        w[j] = (w[j] << 8) | {{24{blk[nw * 4 + k][7]}}, blk[nw * 4 + k]};
                end
            end
        end
        mix(FINAL_ROUNDS, w);
        hash_q.push_back(chain_lo ^ chain_hi);
        messages_noted++;
        restart();
    endfunction

    function void check_hash(logic [31:0] got);
        logic [31:0] want;
        if (hash_q.size() == 0) begin
            $display("%0t: hash with no message pending: expected none, got %08h",
                     $time, got);
            errors++;
            return;
        end
        want = hash_q.pop_front();
        hashes_checked++;
        if (got !== want) begin
            $display("%0t: hash mismatch: expected %08h, got %08h", $time, want, got);
            errors++;
        end
    endfunction

    function int unsigned pending();
        return hash_q.size();
    endfunction

endclass

module davies_meyer_tea_string_hash_tb;

    localparam int TOTAL_WORDS = 1250;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_stall;
    logic [7:0]  i_data_byte;
    logic        i_byte_valid;
    logic        i_last;
    logic        o_valid;
    logic        i_stall;
    logic [31:0] o_hash_value;

    hash_scoreboard sb;

    // idle chances in percent, set by the stimulus phase
    int unsigned send_idle_pct;
    int unsigned recv_idle_pct;
    // words sent (idle words not counted)
    int unsigned words_sent;
    // asks the receiver for one long hold-off
    logic        hold_req;

    davies_meyer_tea_string_hash u_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_data_byte  (i_data_byte),
        .i_byte_valid (i_byte_valid),
        .i_last       (i_last),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_hash_value (o_hash_value)
    );

    initial i_clk = 1'b0;
    always #2 i_clk = ~i_clk;

    // Phase plan: sender idles lightly while the receiver idles heavily, then
    // the other way round, then neither side idles. The long hold-off falls in
    // the last phase so the sender keeps pushing into a blocked result path.
    task automatic set_phase();
        if (words_sent < TOTAL_WORDS / 3) begin
            send_idle_pct = 29;
            recv_idle_pct = 87;
        end else if (words_sent < 2 * TOTAL_WORDS / 3) begin
            send_idle_pct = 87;
            recv_idle_pct = 29;
        end else begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
            if (words_sent > 3 * TOTAL_WORDS / 4) hold_req = 1'b1;
        end
    endtask

    // Offer one input word and wait until it is taken.
    // Acceptance is decided on the falling edge, where o_stall is settled,
    // and takes effect at the next rising edge.
    task automatic offer_word(logic [7:0] d, logic bv, logic lst);
        if ($urandom_range(99) < send_idle_pct) begin
            i_valid      <= 1'b0;
            i_data_byte  <= 8'($urandom);
            i_byte_valid <= 1'($urandom);
            i_last       <= 1'($urandom);
            do @(posedge i_clk); while ($urandom_range(99) < send_idle_pct);
        end
        i_valid      <= 1'b1;
        i_data_byte  <= d;
        i_byte_valid <= bv;
        i_last       <= lst;
        do @(negedge i_clk); while (o_stall);
        @(posedge i_clk);
        sb.note_word(d, bv, lst);
        if (bv || lst) words_sent++;
        set_phase();
    endtask

    // Random message: mostly short, some long, some whole multiples of a block.
    // Idle words are sprinkled in; the end comes either on the last byte or
    // as an empty final word.
    task automatic send_message();
        int unsigned len;
        int unsigned pick;
        logic        end_on_byte;
        pick = $urandom_range(99);
        if (pick < 60)      len = $urandom_range(20, 0);
        else if (pick < 75) len = 16 * $urandom_range(4, 0);
        else if (pick < 92) len = $urandom_range(48, 16);
        else                len = $urandom_range(80, 49);
        end_on_byte = (len != 0) && $urandom_range(1);
        for (int k = 0; k < len; k++) begin
            if ($urandom_range(99) < 8) offer_word(8'($urandom), 1'b0, 1'b0);
            offer_word(8'($urandom), 1'b1, end_on_byte && (k == len - 1));
        end
        if (!end_on_byte) offer_word(8'($urandom), 1'b0, 1'b1);
    endtask

    // Result side: random stall, plus one long hold-off counted here
    initial begin : recv_side
        int unsigned hold_left;
        logic        hold_done;
        hold_left = 0;
        hold_done = 1'b0;
        i_stall   = 1'b1;
        forever begin
            @(posedge i_clk);
            if (hold_req && !hold_done) begin
                hold_done = 1'b1;
                hold_left = 400;
            end
            if (hold_left != 0) begin
                hold_left--;
                i_stall <= 1'b1;
            end else begin
                i_stall <= ($urandom_range(99) < recv_idle_pct);
            end
        end
    end

    // A result word is taken at the rising edge after a falling edge that
    // sees valid high and stall low
    always @(negedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) sb.check_hash(o_hash_value);
    end

    initial begin
        #2_000_000;
        $display("tb: failure");
        $finish;
    end

    initial begin
        sb            = new();
        words_sent    = 0;
        hold_req      = 1'b0;
        send_idle_pct = 29;
        recv_idle_pct = 87;
        i_rst_n       = 1'b0;
        i_valid       = 1'b0;
        i_data_byte   = '0;
        i_byte_valid  = 1'b0;
        i_last        = 1'b0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: idle word, empty message, one negative byte, a three-byte
        // tail with sign-extension on both sides, one whole block ending on
        // its last byte, idle word
        offer_word(8'hA5, 1'b0, 1'b0);
        offer_word(8'h5A, 1'b0, 1'b1);
        offer_word(8'hFF, 1'b1, 1'b1);
        offer_word(8'h80, 1'b1, 1'b0);
        offer_word(8'h00, 1'b1, 1'b0);
        offer_word(8'h7F, 1'b1, 1'b1);
        for (int k = 0; k < 16; k++) begin
            if (k == 0)       offer_word(8'h00, 1'b1, 1'b0);
            else if (k == 15) offer_word(8'hFF, 1'b1, 1'b1);
            else              offer_word(8'($urandom), 1'b1, 1'b0);
        end
        offer_word(8'h3C, 1'b0, 1'b0);

        while (words_sent < TOTAL_WORDS) send_message();

        i_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        // let any stray result show up
        repeat (60) @(posedge i_clk);

        $display("tb: %0d message bytes over %0d messages, %0d hashes checked, %0d errors",
                 sb.bytes_noted, sb.messages_noted, sb.hashes_checked, sb.errors);
        $display("tb: phases with sender idling, receiver idling, none, and one long hold-off");
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

`default_nettype wire
